// ----- rtl/core/bitstream_pack_unpack_macros.svh -----
// Assertion macros shared by the bit packer checker.
`ifndef BITSTREAM_PACK_UNPACK_MACROS_SVH
`define BITSTREAM_PACK_UNPACK_MACROS_SVH

// Checked only while out of reset.
`define BPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define BPU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bpu_pkg.sv -----
// Types, codes and helper functions of the bit packer / unpacker.
package bpu_pkg;

    localparam int CMD_W      = 3;
    localparam int VAL_W      = 64;
    localparam int CNT_W      = 16;
    localparam int ADDR_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int USED_W     = 13;
    localparam int CAP_W      = 13;
    localparam int NBYTES_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_SKIP   = 3'd2,
        CMD_ALIGN  = 3'd3,
        CMD_REWIND = 3'd4,
        CMD_LOAD   = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_SWAP     = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_READ,
        OP_SKIP,
        OP_ALIGN,
        OP_REWIND,
        OP_LOAD
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_MEM
    } bk_state_t;

    typedef struct packed {
        op_t                 op;
        logic                width_ok;
        logic                swap;
        logic [NBYTES_W-1:0] nbytes;
        logic [CNT_W-1:0]    count;
        logic [VAL_W-1:0]    value;
        logic [VAL_W-1:0]    mask;
        logic [ADDR_W-1:0]   load_addr;
        logic [BYTE_W-1:0]   load_data;
    } item_t;

    typedef struct packed {
        logic pop;
        logic hold;
    } bk_ctrl_t;

    // Reverse the low nb bytes of v; bytes above nb must be zero.
    function automatic logic [VAL_W-1:0] swap_bytes(input logic [VAL_W-1:0] v,
                                                    input logic [NBYTES_W-1:0] nb);
        logic [VAL_W-1:0] r;
        logic [6:0]       sh;
        for (int k = 0; k < 8; k++)
        begin
            r[8*k +: 8] = v[8*(7-k) +: 8];
        end
        sh = {4'(4'd8 - nb), 3'b000};
        return r >> sh;
    endfunction

    function automatic logic [VAL_W-1:0] field_mask(input logic [6:0] n);
        return ~({VAL_W{1'b1}} << n);
    endfunction

endpackage

// ----- rtl/core/bpu_if.sv -----
// Request and response channel interfaces of the bit packer / unpacker.
interface bpu_req_if;
    logic                              valid;
    logic                              ready;
    logic [bpu_pkg::CMD_W-1:0]         command;
    logic [bpu_pkg::VAL_W-1:0]         write_value;
    logic [bpu_pkg::CNT_W-1:0]         bit_count;
    logic [bpu_pkg::ADDR_W-1:0]        load_address;
    logic [bpu_pkg::BYTE_W-1:0]        load_data;

    modport source (output valid, output command, output write_value, output bit_count,
                    output load_address, output load_data, input ready);
    modport sink   (input valid, input command, input write_value, input bit_count,
                    input load_address, input load_data, output ready);
endinterface

interface bpu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bpu_pkg::VAL_W-1:0]         read_value;
    logic                              status;
    logic [bpu_pkg::USED_W-1:0]        bytes_used;

    modport source (output valid, output read_value, output status, output bytes_used,
                    input ready);
    modport sink   (input valid, input read_value, input status, input bytes_used,
                    output ready);
endinterface

// ----- rtl/core/bitstream_pack_unpack.sv -----
// Path: skip, align, rewind, unknown commands and failed reads or writes go through
// the request queue and the result register; read, write and load byte add BK_MEM.
// Throughput: one request per cycle for cursor-only commands while rsp.ready holds;
// read, write and load byte hold off the next issue for BK_MEM (read-modify-write
// of a row pair in the two banks). Reset: cursor and config return to defaults; a
// clearing pass then zeroes the store with requests held off.
module bitstream_pack_unpack #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bpu_req_if.sink                           req,
    bpu_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bpu_pkg::*;

    logic [CAP_W-1:0] used_cap_reg;
    logic             swap_reg;
    logic             item_valid;
    item_t            item;
    bk_ctrl_t         ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_cap_reg <= CAP_W'(4096);
            swap_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CAPACITY: used_cap_reg <= cfg_data[CAP_W-1:0];
                CFG_SWAP:     swap_reg     <= cfg_data[0];
                default:      swap_reg     <= swap_reg;
            endcase
        end
    end

    bpu_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .swap_en    (swap_reg),
        .ctrl       (ctrl),
        .item_valid (item_valid),
        .item       (item)
    );

    bpu_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .used_cap   (used_cap_reg),
        .ctrl       (ctrl),
        .rsp        (rsp)
    );
endmodule

// ----- rtl/core/bpu_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bpu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/bpu_front.sv -----
// Front end: decodes requests and queues them for the back end.
module bpu_front #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    bpu_req_if.sink           req,
    input  logic              swap_en,
    input  bpu_pkg::bk_ctrl_t ctrl,
    output logic              item_valid,
    output bpu_pkg::item_t    item
);
    import bpu_pkg::*;

    item_t      fresh;
    logic [VAL_W-1:0] masked;
    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    // Classify the request; width checks and masking do not depend on the cursor.
    always_comb
    begin
        fresh.width_ok  = (req.bit_count != '0) && (req.bit_count <= CNT_W'(64));
        fresh.count     = req.bit_count;
        fresh.nbytes    = NBYTES_W'((req.bit_count[6:0] + 7'd7) >> 3);
        fresh.mask      = field_mask(req.bit_count[6:0]);
        fresh.swap      = swap_en && (req.bit_count > CNT_W'(8));
        fresh.load_addr = req.load_address;
        fresh.load_data = req.load_data;
        masked          = req.write_value & fresh.mask;
        fresh.value     = fresh.swap ? swap_bytes(masked, fresh.nbytes) : masked;
        unique case (cmd_t'(req.command))
            CMD_WRITE:  fresh.op = OP_WRITE;
            CMD_READ:   fresh.op = OP_READ;
            CMD_SKIP:   fresh.op = OP_SKIP;
            CMD_ALIGN:  fresh.op = OP_ALIGN;
            CMD_REWIND: fresh.op = OP_REWIND;
            CMD_LOAD:   fresh.op = (32'(req.load_address) < STORE_DEPTH) ? OP_LOAD : OP_NOP;
            default:    fresh.op = OP_NOP;
        endcase
    end

    assign req.ready  = !ctrl.hold && (count_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        priority if (push && !ctrl.pop)
            count_next = count_reg + 2'd1;
        else if (!push && ctrl.pop)
            count_next = count_reg - 2'd1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (ctrl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end
endmodule

// ----- rtl/core/bpu_back.sv -----
// Back end: cursor, banked byte store and result register.
module bpu_back #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  bpu_pkg::item_t               item,
    input  logic [bpu_pkg::CAP_W-1:0]    used_cap,
    output bpu_pkg::bk_ctrl_t            ctrl,
    bpu_rsp_if.source                    rsp
);
    import bpu_pkg::*;

    localparam int CW         = ($clog2(STORE_DEPTH + 1) > CAP_W) ?
                                $clog2(STORE_DEPTH + 1) : CAP_W;
    localparam int RW         = CW - 3;
    localparam int ROWS       = (STORE_DEPTH + 7) / 8;
    localparam int BANK_DEPTH = (ROWS + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    bk_state_t        state_reg;
    bk_state_t        state_next;
    logic [BAW-1:0]   clr_reg;
    logic [BAW-1:0]   clr_next;

    logic [CW-1:0]    cur_byte_reg;
    logic [CW-1:0]    cur_byte_next;
    logic [2:0]       cur_bit_reg;
    logic [2:0]       cur_bit_next;

    item_t            cur_item_reg;
    logic             lo_bank_reg;
    logic             hi_ok_reg;
    logic [BAW-1:0]   even_addr_reg;
    logic [BAW-1:0]   odd_addr_reg;
    logic [127:0]     shifted_reg;
    logic [15:0]      clip_reg;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_status_reg;
    logic [USED_W-1:0] out_used_reg;

    logic             out_free;
    logic             issue;
    logic             load_out;
    logic [VAL_W-1:0] out_value;
    logic             out_status;
    logic             err;
    logic [CW-1:0]    eff_cap;

    logic [RW-1:0]    sel_row;
    logic [BAW-1:0]   half;
    logic             hi_ok;
    logic [CW-1:0]    limit;
    logic [15:0]      clip;
    logic [127:0]     shifted;
    logic [5:0]       off;

    logic [CNT_W-1:0] adv_amt;
    logic             adv_en;
    logic [CNT_W:0]   tmp;
    logic [CW:0]      nb;
    logic             sat;
    logic [CW:0]      used;

    logic [VAL_W-1:0] even_q;
    logic [VAL_W-1:0] odd_q;
    logic [VAL_W-1:0] lo_q;
    logic [VAL_W-1:0] hi_q;
    logic [127:0]     em;
    logic [127:0]     rd_shift;
    logic [VAL_W-1:0] rd_low;
    logic [VAL_W-1:0] rd_val;
    logic [127:0]     wr_pair;
    logic [VAL_W-1:0] lo_load;
    logic [VAL_W-1:0] lo_wdata;
    logic             mem_wr;
    logic             even_we;
    logic             odd_we;
    logic [BAW-1:0]   even_waddr;
    logic [BAW-1:0]   odd_waddr;
    logic [VAL_W-1:0] even_wdata;
    logic [VAL_W-1:0] odd_wdata;
    logic [BAW-1:0]   even_raddr;

    assign eff_cap  = (CW'(used_cap) < CW'(STORE_DEPTH)) ? CW'(used_cap) : CW'(STORE_DEPTH);
    assign out_free = !out_valid_reg || rsp.ready;
    assign issue    = (state_reg == BK_RUN) && item_valid && out_free;
    assign err      = ((item.op == OP_WRITE) || (item.op == OP_READ)) &&
                      (!item.width_ok || (cur_byte_reg >= eff_cap));

    assign ctrl.pop  = issue;
    assign ctrl.hold = (state_reg == BK_CLEAR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + BAW'(1);
                if (clr_reg == BAW'(BANK_DEPTH - 1))
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (issue && !err && ((item.op == OP_WRITE) || (item.op == OP_READ) ||
                                      (item.op == OP_LOAD)))
                begin
                    state_next = BK_MEM;
                end
            end
            BK_MEM:
            begin
                state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // Issue side: window row pair, write data placement and capacity clip
    always_comb
    begin
        sel_row = (item.op == OP_LOAD) ? RW'(item.load_addr[ADDR_W-1:3])
                                       : cur_byte_reg[CW-1:3];
        half    = BAW'(sel_row >> 1);
        hi_ok   = (32'(sel_row) + 32'd1) < ROWS;
        limit   = eff_cap - {sel_row, 3'b000};
        for (int j = 0; j < 16; j++)
        begin
            clip[j] = (CW'(j) < limit);
        end
        shifted = {64'd0, item.value} << off;
        for (int j = 0; j < 16; j++)
        begin
            shifted[8*j +: 8] = shifted[8*j +: 8] & {8{clip[j]}};
        end
        even_raddr = sel_row[0] ? (hi_ok ? half + BAW'(1) : '0) : half;
    end

    assign off = {cur_byte_reg[2:0], cur_bit_reg};

    // Access side: row pair from both banks
    always_comb
    begin
        lo_q = lo_bank_reg ? odd_q : even_q;
        hi_q = lo_bank_reg ? even_q : odd_q;
        for (int j = 0; j < 16; j++)
        begin
            em[8*j +: 8] = {8{clip_reg[j]}};
        end
        rd_shift = ({hi_q, lo_q} & em) >> off;
        rd_low   = rd_shift[VAL_W-1:0] & cur_item_reg.mask;
        rd_val   = cur_item_reg.swap ? swap_bytes(rd_low, cur_item_reg.nbytes) : rd_low;
        wr_pair  = {hi_q, lo_q} | shifted_reg;
        for (int k = 0; k < 8; k++)
        begin
            lo_load[8*k +: 8] = (3'(k) == cur_item_reg.load_addr[2:0]) ?
                                cur_item_reg.load_data : lo_q[8*k +: 8];
        end
        lo_wdata = (cur_item_reg.op == OP_LOAD) ? lo_load : wr_pair[VAL_W-1:0];
    end

    // Bank write ports: clearing pass, then read-modify-write
    always_comb
    begin
        mem_wr = (state_reg == BK_MEM) &&
                 ((cur_item_reg.op == OP_WRITE) || (cur_item_reg.op == OP_LOAD));
        if (state_reg == BK_CLEAR)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = clr_reg;
            odd_waddr  = clr_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else
        begin
            even_waddr = even_addr_reg;
            odd_waddr  = odd_addr_reg;
            if (lo_bank_reg)
            begin
                odd_we     = mem_wr;
                even_we    = mem_wr && (cur_item_reg.op == OP_WRITE) && hi_ok_reg;
                odd_wdata  = lo_wdata;
                even_wdata = wr_pair[127:64];
            end
            else
            begin
                even_we    = mem_wr;
                odd_we     = mem_wr && (cur_item_reg.op == OP_WRITE) && hi_ok_reg;
                even_wdata = lo_wdata;
                odd_wdata  = wr_pair[127:64];
            end
        end
    end

    bpu_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    bpu_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .raddr (half),
        .rdata (odd_q)
    );

    // Result and cursor control
    always_comb
    begin
        load_out   = 1'b0;
        out_value  = '0;
        out_status = 1'b0;
        adv_en     = 1'b0;
        adv_amt    = '0;
        unique case (state_reg)
            BK_RUN:
            begin
                if (issue)
                begin
                    unique case (item.op)
                        OP_WRITE, OP_READ:
                        begin
                            load_out   = err;
                            out_status = err;
                        end
                        OP_LOAD:
                        begin
                            load_out = 1'b0;
                        end
                        OP_SKIP:
                        begin
                            load_out = 1'b1;
                            adv_en   = 1'b1;
                            adv_amt  = item.count;
                        end
                        OP_ALIGN:
                        begin
                            load_out = 1'b1;
                            adv_en   = 1'b1;
                            adv_amt  = (cur_bit_reg == 3'd0) ? '0
                                     : CNT_W'(4'd8 - {1'b0, cur_bit_reg});
                        end
                        OP_REWIND, OP_NOP:
                        begin
                            load_out = 1'b1;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_MEM:
            begin
                load_out = 1'b1;
                if (cur_item_reg.op != OP_LOAD)
                begin
                    adv_en  = 1'b1;
                    adv_amt = cur_item_reg.count;
                end
                if (cur_item_reg.op == OP_READ)
                begin
                    out_value = rd_val;
                end
            end
            BK_CLEAR:
            begin
                load_out = 1'b0;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Advance or rewind the cursor, saturating at the end of the store
    always_comb
    begin
        tmp = (CNT_W+1)'(cur_bit_reg) + (CNT_W+1)'(adv_amt);
        nb  = (CW+1)'(cur_byte_reg) + (CW+1)'(tmp >> 3);
        sat = (nb > (CW+1)'(STORE_DEPTH)) ||
              ((nb == (CW+1)'(STORE_DEPTH)) && (tmp[2:0] != 3'd0));
        cur_byte_next = cur_byte_reg;
        cur_bit_next  = cur_bit_reg;
        if (issue && (item.op == OP_REWIND))
        begin
            cur_byte_next = '0;
            cur_bit_next  = 3'd0;
        end
        else if (adv_en)
        begin
            cur_byte_next = sat ? CW'(STORE_DEPTH) : CW'(nb);
            cur_bit_next  = sat ? 3'd0 : tmp[2:0];
        end
        used = (CW+1)'(cur_byte_next) + (CW+1)'(cur_bit_next != 3'd0);
        if (used > (CW+1)'(STORE_DEPTH))
        begin
            used = (CW+1)'(STORE_DEPTH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cur_item_reg  <= item;
            lo_bank_reg   <= sel_row[0];
            hi_ok_reg     <= hi_ok;
            even_addr_reg <= even_raddr;
            odd_addr_reg  <= half;
            shifted_reg   <= shifted;
            clip_reg      <= clip;
        end
        if (load_out)
        begin
            out_value_reg  <= out_value;
            out_status_reg <= out_status;
            out_used_reg   <= USED_W'(used);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            cur_byte_reg  <= '0;
            cur_bit_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cur_byte_reg <= cur_byte_next;
            cur_bit_reg  <= cur_bit_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.bytes_used = out_used_reg;
endmodule

// ----- rtl/core/bpu_checker.sv -----
// Port-level checker for the bit packer / unpacker, bound to the top level.
`include "bitstream_pack_unpack_macros.svh"

module bpu_checker #(
    parameter int STORE_DEPTH = 4096
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_read_value,
    input logic        rsp_status,
    input logic [12:0] rsp_bytes_used
);
    // A failed request never returns data.
    `BPU_ASSERT(a_err_no_data,
                rsp_valid && rsp_status |-> rsp_read_value == 64'd0,
                "error response carries data")

    // Cursor is saturated at the end of the store.
    `BPU_ASSERT(a_used_bound,
                rsp_valid |-> 32'(rsp_bytes_used) <= STORE_DEPTH,
                "bytes_used past store")

    // Hold a stalled response.
    `BPU_ASSERT(a_rsp_hold,
                rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
                    $stable(rsp_bytes_used),
                "stalled response changed")

    // The store clears after reset, so no request is taken right away.
    `BPU_ASSERT_ALWAYS(a_clear_blocks, !rst_n |=> !req_ready, "request taken during clearing")
endmodule

bind bitstream_pack_unpack bpu_checker #(
    .STORE_DEPTH (STORE_DEPTH)
) u_bpu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status),
    .rsp_bytes_used (rsp.bytes_used)
);

// ----- tb/bitstream_pack_unpack_checker.sv -----
// Response checker for the bit packer / unpacker: predicts every request, compares responses.
`timescale 1ns / 100ps

module bitstream_pack_unpack_checker (
    input  logic                           clk,
    bpu_req_if                             req,
    bpu_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);
    import bpu_pkg::*;

    localparam int DEPTH = 4096;

    typedef struct {
        logic [VAL_W-1:0]  read_value;
        logic              status;
        logic [USED_W-1:0] bytes_used;
    } bpu_result_t;

    logic [7:0]        store_bytes [DEPTH];
    int unsigned       cur_byte;
    int unsigned       cur_bit;
    logic [CAP_W-1:0]  capacity;
    logic              swap_en;
    bpu_result_t       expected_q [$];

    initial
    begin
        foreach (store_bytes[i])
            store_bytes[i] = 8'h00;
        cur_byte = 0;
        cur_bit  = 0;
        capacity = CAP_W'(DEPTH);
        swap_en  = 1'b0;
        errors   = 0;
    end

    assign pending = expected_q.size();

    function automatic logic [VAL_W-1:0] byte_reverse(input logic [VAL_W-1:0] v,
                                                      input int unsigned nbytes);
        logic [VAL_W-1:0] r;
        r = '0;
        if (nbytes < 2)
            return v;
        for (int k = 0; k < nbytes; k++)
            r[8*(nbytes-1-k) +: 8] = v[8*k +: 8];
        return r;
    endfunction

    // Saturate at the end of the store, bit 0.
    function automatic void move_cursor(input longint unsigned bits);
        longint unsigned tmp;
        longint unsigned nb;
        tmp = cur_bit + bits;
        nb  = cur_byte + (tmp >> 3);
        if (nb > DEPTH || (nb == DEPTH && tmp[2:0] != 0))
        begin
            cur_byte = DEPTH;
            cur_bit  = 0;
        end
        else
        begin
            cur_byte = nb;
            cur_bit  = tmp[2:0];
        end
    endfunction

    function automatic bpu_result_t predict_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [VAL_W-1:0] wval,
                                                    input logic [CNT_W-1:0] nbits,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [BYTE_W-1:0] data);
        bpu_result_t      res;
        int unsigned      cap;
        int unsigned      win;
        int unsigned      nbytes;
        logic             do_swap;
        logic [VAL_W-1:0] mask;
        logic [VAL_W-1:0] v;
        logic [127:0]     wide;
        int unsigned      used;
        res.read_value = '0;
        res.status     = 1'b0;
        cap = (capacity < DEPTH) ? capacity : DEPTH;
        if (cmd == CMD_WRITE || cmd == CMD_READ)
        begin
            if (nbits == 0 || nbits > 64 || cur_byte >= cap)
                res.status = 1'b1;
            else
            begin
                mask    = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
                win     = (cap - cur_byte < 9) ? cap - cur_byte : 9;
                nbytes  = (nbits + 7) / 8;
                do_swap = swap_en && nbits > 8;
                if (cmd == CMD_WRITE)
                begin
                    v = wval & mask;
                    if (do_swap)
                        v = byte_reverse(v, nbytes);
                    wide = {64'd0, v} << cur_bit;
                    for (int k = 0; k < win; k++)
                        store_bytes[cur_byte + k] |= wide[8*k +: 8];
                end
                else
                begin
                    wide = '0;
                    for (int k = 0; k < win; k++)
                        wide[8*k +: 8] = store_bytes[cur_byte + k];
                    wide = wide >> cur_bit;
                    v = wide[63:0] & mask;
                    if (do_swap)
                        v = byte_reverse(v, nbytes);
                    res.read_value = v;
                end
                move_cursor(nbits);
            end
        end
        else if (cmd == CMD_SKIP)
            move_cursor(nbits);
        else if (cmd == CMD_ALIGN)
        begin
            if (cur_bit != 0)
                move_cursor(8 - cur_bit);
        end
        else if (cmd == CMD_REWIND)
        begin
            cur_byte = 0;
            cur_bit  = 0;
        end
        else if (cmd == CMD_LOAD)
            store_bytes[addr] = data;
        used = cur_byte + (cur_bit != 0);
        if (used > DEPTH)
            used = DEPTH;
        res.bytes_used = USED_W'(used);
        return res;
    endfunction

    always @(posedge clk)
    begin
        bpu_result_t exp_r;
        if (rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected response value=%h status=%b used=%0d",
                             $realtime, rsp.read_value, rsp.status, rsp.bytes_used);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (rsp.read_value !== exp_r.read_value || rsp.status !== exp_r.status ||
                    rsp.bytes_used !== exp_r.bytes_used)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: expected value=%h status=%b used=%0d, got %h %b %0d",
                                 $realtime, exp_r.read_value, exp_r.status,
                                 exp_r.bytes_used, rsp.read_value, rsp.status,
                                 rsp.bytes_used);
                end
            end
        end
        if (req.valid && req.ready)
            expected_q.push_back(predict_request(req.command, req.write_value,
                                                 req.bit_count, req.load_address,
                                                 req.load_data));
        if (cfg_we)
        begin
            if (cfg_index == CFG_CAPACITY)
                capacity = cfg_data;
            else if (cfg_index == CFG_SWAP)
                swap_en = cfg_data[0];
        end
    end

endmodule

// ----- tb/bitstream_pack_unpack_tb.sv -----
// Stimulus, clock, reset and verdict for the bit packer / unpacker.
`timescale 1ns / 100ps

module bitstream_pack_unpack_tb;
    import bpu_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_ITEMS   = 230;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    idle_cycles;
    int                    stall_left;
    logic                  no_stall;

    bpu_req_if req ();
    bpu_rsp_if rsp ();

    bitstream_pack_unpack i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bitstream_pack_unpack_checker i_checker (
        .clk       (clk),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random backpressure on the response side.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp.ready  <= 1'b1;
            stall_left <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] wval,
                                input logic [CNT_W-1:0] nbits,
                                input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.write_value  <= wval;
        req.bit_count    <= nbits;
        req.load_address <= addr;
        req.load_data    <= data;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Hold off requests until every response has come back.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(input int items);
        int               done;
        int               nf;
        int               widths [8];
        logic [CMD_W-1:0] cmd;
        logic [CNT_W-1:0] cnt;
        done = 0;
        while (done < items)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                // Well-formed packet: rewind, maybe skip, pack fields, rewind, read the same widths back, maybe align.
                nf = $urandom_range(1, 8);
                send_request(CMD_REWIND, rand_word(), 16'd0, 12'd0, 8'd0);
                if ($urandom_range(0, 3) == 0)
                    send_request(CMD_SKIP, rand_word(), CNT_W'($urandom_range(1, 40)),
                                 12'd0, 8'd0);
                for (int i = 0; i < nf; i++)
                begin
                    widths[i] = $urandom_range(1, 64);
                    send_request(CMD_WRITE, rand_word(), CNT_W'(widths[i]),
                                 ADDR_W'($urandom()), BYTE_W'($urandom()));
                end
                send_request(CMD_REWIND, rand_word(), 16'd0, 12'd0, 8'd0);
                for (int i = 0; i < nf; i++)
                    send_request(CMD_READ, rand_word(), CNT_W'(widths[i]), 12'd0, 8'd0);
                if ($urandom_range(0, 1) == 0)
                    send_request(CMD_ALIGN, rand_word(), 16'd0, 12'd0, 8'd0);
                done += 2 * nf + 2;
            end
            else
            begin
                cmd = CMD_W'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0:       cnt = CNT_W'($urandom_range(0, 32768));
                    1:       cnt = 16'd0;
                    2:       cnt = CNT_W'($urandom_range(65, 200));
                    default: cnt = CNT_W'($urandom_range(1, 64));
                endcase
                send_request(cmd, rand_word(), cnt, ADDR_W'($urandom()), BYTE_W'($urandom()));
                done++;
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_CAPACITY;
        cfg_data        = '0;
        req.valid       = 1'b0;
        req.command     = CMD_REWIND;
        req.write_value = '0;
        req.bit_count   = '0;
        req.load_address = '0;
        req.load_data   = '0;
        rsp.ready       = 1'b0;
        stall_left      = 0;
        no_stall        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: widths at and past the limits, all commands, saturation, clipping.
        send_request(CMD_WRITE, '1, 16'd64, 12'd0, 8'd0);
        send_request(CMD_WRITE, 64'h5, 16'd3, 12'd0, 8'd0);
        send_request(CMD_WRITE, '1, 16'd0, 12'd0, 8'd0);
        send_request(CMD_WRITE, '1, 16'd65, 12'd0, 8'd0);
        send_request(CMD_WRITE, 64'h0123_4567_89AB_CDEF, 16'd64, 12'd0, 8'd0);
        send_request(CMD_ALIGN, '0, 16'd0, 12'd0, 8'd0);
        send_request(CMD_REWIND, '0, 16'd0, 12'd0, 8'd0);
        send_request(CMD_READ, '0, 16'd64, 12'd0, 8'd0);
        send_request(CMD_READ, '0, 16'd3, 12'd0, 8'd0);
        send_request(CMD_READ, '0, 16'd64, 12'd0, 8'd0);
        send_request(CMD_READ, '0, 16'hFFFF, 12'd0, 8'd0);
        send_request(CMD_LOAD, '0, 16'd0, 12'd4095, 8'hFF);
        send_request(CMD_LOAD, '0, 16'd0, 12'd0, 8'hA5);
        send_request(CMD_RSVD_LO, '1, 16'hFFFF, 12'hFFF, 8'hFF);
        send_request(CMD_RSVD_HI, '1, 16'd5, 12'd0, 8'd0);
        send_request(CMD_SKIP, '0, 16'd32768, 12'd0, 8'd0);
        send_request(CMD_WRITE, '1, 16'd8, 12'd0, 8'd0);
        send_request(CMD_ALIGN, '0, 16'd0, 12'd0, 8'd0);
        send_request(CMD_REWIND, '0, 16'd0, 12'd0, 8'd0);
        send_request(CMD_SKIP, '0, 16'd32763, 12'd0, 8'd0);
        send_request(CMD_READ, '0, 16'd64, 12'd0, 8'd0);
        send_request(CMD_ALIGN, '0, 16'd0, 12'd0, 8'd0);
        drain();

        random_phase(PHASE_ITEMS);
        write_config(CFG_SWAP, 13'd1);
        random_phase(PHASE_ITEMS);
        write_config(CFG_CAPACITY, 13'd1);
        no_stall = 1'b1;
        random_phase(PHASE_ITEMS / 2);
        no_stall = 1'b0;
        write_config(CFG_CAPACITY, CFG_DATA_W'($urandom_range(9, 40)));
        random_phase(PHASE_ITEMS);
        write_config(CFG_SWAP, 13'd0);
        write_config(CFG_CAPACITY, 13'd4096);
        random_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- bitstream_pack_unpack.f -----
+incdir+rtl/core
rtl/core/bpu_pkg.sv
rtl/core/bpu_if.sv
rtl/core/bpu_ram.sv
rtl/core/bpu_front.sv
rtl/core/bpu_back.sv
rtl/core/bitstream_pack_unpack.sv
rtl/core/bpu_checker.sv
tb/bitstream_pack_unpack_checker.sv
tb/bitstream_pack_unpack_tb.sv
